/* rtl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Sizes of the chunk table, command and status codes, and the types used
// between the controller and the row of chunk cells.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int MAX_CHUNKS   = 64;
    // ALIGN_BYTES must be a power of two; rounding is done with a mask.
    localparam int ALIGN_BYTES  = 16;
    localparam int HEADER_BYTES = 16;

    localparam int IDX_W   = $clog2(MAX_CHUNKS);
    localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
    localparam int PADDR_W = 3;

    localparam logic [31:0] HEAP_START_RST = 32'd0;
    localparam logic [31:0] HEAP_SIZE_RST  = 32'd1048576;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_FIT   = 2'd1;
    localparam logic [1:0] STAT_BAD_FREE = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // Register index as decoded from paddr[2].
    localparam logic REG_HEAP_START = 1'b0;

    typedef struct packed {
        logic [31:0] bytes;
        logic        used;
    } t_entry;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_WRITE,
        OP_INSERT,
        OP_DELETE,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] k;
        t_entry           val;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_INSERT,
        S_DELETE,
        S_DONE
    } t_state;

endpackage

/* rtl/ffha_cell.sv */
// ----------------------------------------------------------------------------
// ffha_cell: one entry of the chunk table
// Holds a chunk size and used mark and trades them with its neighbors on
// rotate, insert and delete commands broadcast by the controller.
// ----------------------------------------------------------------------------
module ffha_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ffha_pkg::t_cell_cmd          i_cmd,
    input  logic [ffha_pkg::IDX_W-1:0]   i_index,
    input  ffha_pkg::t_entry             i_left,
    input  ffha_pkg::t_entry             i_right,
    output ffha_pkg::t_entry             o_entry
);
    import ffha_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_first;
    logic   w_last;

    assign w_first = (i_index == '0);
    assign w_last  = (i_index == IDX_W'(MAX_CHUNKS - 1));

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            OP_HOLD:   n_entry = r_entry;
            OP_ROTATE: n_entry = i_right;
            OP_WRITE: begin
                if (i_index == i_cmd.k) n_entry = i_cmd.val;
            end
            OP_INSERT: begin
                if (i_index == i_cmd.k) n_entry = i_cmd.val;
                else if (i_index > i_cmd.k) n_entry = i_left;
            end
            OP_DELETE: begin
                if (i_index >= i_cmd.k) n_entry = w_last ? '0 : i_right;
            end
            OP_CLEAR: n_entry = w_first ? t_entry'{i_cmd.val.bytes, 1'b0} : '0;
            default:  n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= w_first ? t_entry'{HEAP_SIZE_RST, 1'b0} : '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

/* rtl/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap allocator with coalescing
// Keeps an address-ordered table of heap chunks in a ring of cells and
// serves allocate, free and reinitialize commands one item at a time.
// ----------------------------------------------------------------------------
//
//   channel  | valid   | stall   | fields
//   ---------+---------+---------+--------------------------------------
//   command  | i_valid | o_stall | i_cmd, i_req_bytes, i_block_addr
//   result   | o_valid | i_stall | o_status, o_data_addr
//   config   | APB     | pready  | heap_start (0x0), heap_size (0x4)
//
// An allocate or free rotates the table once through the ring, one entry
// per cycle past the controller; the table is then edited in the evaluate
// state and, where needed, the insert or delete state. Reinitialize and the
// unused command go from idle straight to the done state.
// Reset (synchronous, active low) leaves one free chunk of 1 MiB at address 0.
// A finished result waits in the output register while the next item is
// already taken; the block only holds a new result back while i_stall is high.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_cmd,
    input  logic [31:0]                    i_req_bytes,
    input  logic [31:0]                    i_block_addr,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_status,
    output logic [31:0]                    o_data_addr,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffha_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ffha_pkg::*;

    // Configuration registers. They reach the table only at reset and on
    // a reinitialize command; heap_start is used directly by every search.
    logic [31:0] r_heap_start;
    logic [31:0] r_heap_size;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEAP_START) ? r_heap_start : r_heap_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= HEAP_START_RST;
            r_heap_size  <= HEAP_SIZE_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HEAP_START) r_heap_start <= pwdata;
            else r_heap_size <= pwdata;
        end
    end

    // Ring of cells. Cell 0 is the head the controller looks at during a
    // rotation; after MAX_CHUNKS rotations the ring is back in place.
    t_cell_cmd w_cmd;
    t_entry    w_entry [MAX_CHUNKS];

    for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cell
        localparam int LEFT  = (g + MAX_CHUNKS - 1) % MAX_CHUNKS;
        localparam int RIGHT = (g + 1) % MAX_CHUNKS;
        ffha_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(g)),
            .i_left  (w_entry[LEFT]),
            .i_right (w_entry[RIGHT]),
            .o_entry (w_entry[g])
        );
    end

    // Controller state.
    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_step;
    logic [CNT_W-1:0] r_count;
    logic [1:0]       r_cmd;
    logic [33:0]      r_need;
    logic [31:0]      r_off;
    logic [31:0]      r_addr;
    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_hit;
    logic             r_left;
    logic             r_right;
    logic             r_want_next;
    t_entry           r_prev;
    logic [1:0]       r_dels;
    logic [1:0]       r_status;
    logic [31:0]      r_data;
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [31:0]      r_out_addr;

    logic             w_accept;
    logic             w_out_take;
    logic             w_out_load;
    t_entry           w_head;
    logic             w_head_valid;
    logic             w_scan_last;
    logic             w_match;
    logic             w_alloc_ok;
    logic [IDX_W-1:0] w_tgt;
    logic [33:0]      w_round;

    assign w_accept     = i_valid && !o_stall;
    assign w_out_take   = r_out_valid && !i_stall;
    assign w_out_load   = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign w_head       = w_entry[0];
    assign w_head_valid = ({1'b0, r_step} < r_count);
    assign w_scan_last  = (r_step == IDX_W'(MAX_CHUNKS - 1));
    assign w_round      = ({2'b00, i_req_bytes} + 34'(ALIGN_BYTES - 1))
                          & ~34'(ALIGN_BYTES - 1);

    // An allocate looks for the first free chunk that keeps a minimum chunk
    // after carving; a free looks for the used chunk whose data address is
    // the given one (r_off runs as heap_start + header + offset).
    always_comb begin
        if (r_cmd == CMD_ALLOC) begin
            w_match = w_head_valid && !w_head.used &&
                      ({2'b00, w_head.bytes} >= r_need + 34'(ALIGN_BYTES + HEADER_BYTES));
        end else begin
            w_match = w_head_valid && w_head.used && (r_off == r_addr);
        end
    end

    assign w_alloc_ok = (r_need[33:32] == 2'b00) && r_found &&
                        (r_count != CNT_W'(MAX_CHUNKS));
    // The merged chunk lands on the left neighbor when that one is free.
    assign w_tgt      = r_left ? (r_idx - IDX_W'(1)) : r_idx;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_ALLOC || i_cmd == CMD_FREE) n_state = S_SCAN;
                    else n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (w_scan_last) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_cmd == CMD_ALLOC) n_state = w_alloc_ok ? S_INSERT : S_DONE;
                else if (r_found && (r_left || r_right)) n_state = S_DELETE;
                else n_state = S_DONE;
            end
            S_INSERT: n_state = S_DONE;
            S_DELETE: begin
                if (r_dels == 2'd1) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: commands to the cell ring and the input stall.
    always_comb begin
        w_cmd   = '{op: OP_HOLD, k: '0, val: '0};
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_cmd == CMD_INIT) begin
                    w_cmd.op        = OP_CLEAR;
                    w_cmd.val.bytes = r_heap_size;
                end
            end
            S_SCAN: w_cmd.op = OP_ROTATE;
            S_EVAL: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (w_alloc_ok) begin
                        w_cmd.op        = OP_WRITE;
                        w_cmd.k         = r_idx;
                        w_cmd.val.bytes = r_hit - r_need[31:0];
                    end
                end else if (r_found) begin
                    w_cmd.op        = OP_WRITE;
                    w_cmd.k         = w_tgt;
                    w_cmd.val.bytes = r_hit;
                end
            end
            S_INSERT: begin
                w_cmd.op  = OP_INSERT;
                w_cmd.k   = r_idx + IDX_W'(1);
                w_cmd.val = '{bytes: r_need[31:0], used: 1'b1};
            end
            S_DELETE: begin
                w_cmd.op = OP_DELETE;
                w_cmd.k  = r_idx + IDX_W'(1);
            end
            S_DONE: w_cmd.op = OP_HOLD;
            default: w_cmd.op = OP_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(1);
            r_step      <= '0;
            r_found     <= 1'b0;
            r_want_next <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_out_load) r_out_valid <= 1'b1;
            else if (w_out_take) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd       <= i_cmd;
                        r_need      <= w_round + 34'(HEADER_BYTES);
                        r_addr      <= i_block_addr;
                        r_off       <= r_heap_start + 32'(HEADER_BYTES);
                        r_step      <= '0;
                        r_found     <= 1'b0;
                        r_left      <= 1'b0;
                        r_right     <= 1'b0;
                        r_want_next <= 1'b0;
                        r_dels      <= 2'd0;
                        r_status    <= STAT_OK;
                        r_data      <= '0;
                        if (i_cmd == CMD_INIT) r_count <= CNT_W'(1);
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + IDX_W'(1);
                    r_prev <= w_head;
                    if (r_want_next) begin
                        // Entry right after a freed chunk: merge it if free.
                        r_want_next <= 1'b0;
                        if (w_head_valid && !w_head.used) begin
                            r_hit   <= r_hit + w_head.bytes;
                            r_right <= 1'b1;
                        end
                    end
                    if (!r_found) begin
                        if (w_match) begin
                            r_found <= 1'b1;
                            r_idx   <= r_step;
                            if (r_cmd == CMD_FREE) begin
                                r_want_next <= 1'b1;
                                if (r_step != '0 && !r_prev.used) begin
                                    r_left <= 1'b1;
                                    r_hit  <= w_head.bytes + r_prev.bytes;
                                end else begin
                                    r_hit <= w_head.bytes;
                                end
                            end else begin
                                r_hit <= w_head.bytes;
                            end
                        end else begin
                            r_off <= r_off + w_head.bytes;
                        end
                    end
                end
                S_EVAL: begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (r_need[33:32] != 2'b00 || !r_found) r_status <= STAT_NO_FIT;
                        else if (r_count == CNT_W'(MAX_CHUNKS)) r_status <= STAT_FULL;
                        else r_hit <= r_hit - r_need[31:0];
                    end else if (!r_found) begin
                        r_status <= STAT_BAD_FREE;
                    end else begin
                        r_idx  <= w_tgt;
                        r_dels <= {1'b0, r_left} + {1'b0, r_right};
                    end
                end
                S_INSERT: begin
                    // The new block sits at the top of the carved chunk.
                    r_data  <= r_off + r_hit;
                    r_count <= r_count + CNT_W'(1);
                end
                S_DELETE: begin
                    r_dels  <= r_dels - 2'd1;
                    r_count <= r_count - CNT_W'(1);
                end
                S_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data_addr = r_out_addr;

endmodule

/* verif/first_fit_heap_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb: self-checking bench of the heap allocator
// A queue of commands feeds a clocked driver, and a clocked monitor compares
// every result with a predicted one. Several heap settings are used, written
// through the configuration port while the block is idle.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] req_bytes;
        logic [31:0] block_addr;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_addr;
    } t_res_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_cmd = CMD_ALLOC;
    logic [31:0]          i_req_bytes = '0;
    logic [31:0]          i_block_addr = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [1:0]           o_status;
    logic [31:0]          o_data_addr;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    first_fit_heap_allocator u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's chunk table and registers.
    logic [31:0] heap_base;
    logic [31:0] heap_len;
    logic [31:0] chunk_len [MAX_CHUNKS];
    logic        slot_busy [MAX_CHUNKS];
    int          num_chunks;

    t_cmd_item   pending_cmds [$];
    t_res_item   expected_results [$];
    logic [31:0] live_blocks [$];
    int          errors = 0;
    int          send_idle_pct = 35;
    int          recv_idle_pct = 78;
    int          quiet_cycles = 0;

    function automatic void rebuild_heap();
        for (int k = 0; k < MAX_CHUNKS; k++) begin
            chunk_len[k] = '0;
            slot_busy[k] = 1'b0;
        end
        chunk_len[0] = heap_len;
        num_chunks = 1;
    endfunction

    function automatic void remove_chunk(int k);
        for (int j = k; j + 1 < num_chunks; j++) begin
            chunk_len[j] = chunk_len[j+1];
            slot_busy[j] = slot_busy[j+1];
        end
        num_chunks--;
        chunk_len[num_chunks] = '0;
        slot_busy[num_chunks] = 1'b0;
    endfunction

    // Runs one command on the shadow table and returns its result.
    function automatic t_res_item apply_heap_cmd(t_cmd_item c);
        t_res_item   r;
        logic [33:0] need;
        logic [33:0] thresh;
        logic [31:0] off;
        int          i;
        r = '0;
        off = '0;
        if (c.cmd == CMD_ALLOC) begin
            need = ((34'(c.req_bytes) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES
                   + HEADER_BYTES;
            thresh = need + ALIGN_BYTES + HEADER_BYTES;
            if (need > 34'hFFFF_FFFF) begin
                r.status = STAT_NO_FIT;
                return r;
            end
            for (i = 0; i < num_chunks; i++) begin
                if (!slot_busy[i] && 34'(chunk_len[i]) >= thresh) break;
                off += chunk_len[i];
            end
            if (i >= num_chunks) r.status = STAT_NO_FIT;
            else if (num_chunks >= MAX_CHUNKS) r.status = STAT_FULL;
            else begin
                for (int j = num_chunks; j > i + 1; j--) begin
                    chunk_len[j] = chunk_len[j-1];
                    slot_busy[j] = slot_busy[j-1];
                end
                chunk_len[i] -= need[31:0];
                chunk_len[i+1] = need[31:0];
                slot_busy[i+1] = 1'b1;
                num_chunks++;
                off += chunk_len[i];
                r.data_addr = heap_base + off + HEADER_BYTES;
            end
        end else if (c.cmd == CMD_FREE) begin
            for (i = 0; i < num_chunks; i++) begin
                if (slot_busy[i] && heap_base + off + HEADER_BYTES == c.block_addr) break;
                off += chunk_len[i];
            end
            if (i >= num_chunks) r.status = STAT_BAD_FREE;
            else begin
                slot_busy[i] = 1'b0;
                while (i > 0 && !slot_busy[i-1]) begin
                    chunk_len[i-1] += chunk_len[i];
                    remove_chunk(i);
                    i--;
                end
                while (i + 1 < num_chunks && !slot_busy[i+1]) begin
                    chunk_len[i] += chunk_len[i+1];
                    remove_chunk(i + 1);
                end
            end
        end else if (c.cmd == CMD_INIT) begin
            rebuild_heap();
        end
        return r;
    endfunction

    // Driver: presents queued commands, with random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_cmd_item c;
                    c = pending_cmds.pop_front();
                    expected_results.push_back(apply_heap_cmd(c));
                    i_valid <= 1'b1;
                    i_cmd <= c.cmd;
                    i_req_bytes <= c.req_bytes;
                    i_block_addr <= c.block_addr;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // The prediction is made when the item is handed to the driver; since the
    // block handles items strictly in order, this matches acceptance order.

    // Monitor: compares results and drives random stalls.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                t_res_item e;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d addr=%h",
                             $time, o_status, o_data_addr);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_status !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, o_status);
                        errors++;
                    end
                    if (o_data_addr !== e.data_addr) begin
                        $display("%0t: data_addr expected %h actual %h",
                                 $time, e.data_addr, o_data_addr);
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (quiet_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 0) heap_base = val;
        else heap_len = val;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (3 * MAX_CHUNKS) @(posedge i_clk);
    endtask

    function automatic void push_cmd(logic [1:0] c, logic [31:0] req, logic [31:0] addr);
        pending_cmds.push_back('{cmd: c, req_bytes: req, block_addr: addr});
    endfunction

    // Mostly small allocations and frees. Most frees take an address that an
    // earlier allocation returned or a guess near the top of the heap, so
    // some of them turn into bad frees.
    function automatic void push_random(int n);
        logic [31:0] a;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0: push_cmd(CMD_INIT, $urandom, $urandom);
                1: push_cmd(CMD_UNUSED, $urandom, $urandom);
                2: push_cmd(CMD_ALLOC, $urandom, $urandom);
                3: push_cmd(CMD_FREE, $urandom, $urandom);
                4, 5, 6, 7, 8, 9, 10:
                    push_cmd(CMD_ALLOC, $urandom_range(20000), $urandom);
                default: begin
                    // Guess a live data address: heap base plus a slot near the top.
                    a = heap_base + heap_len - 16 * $urandom_range(1, 400);
                    if (live_blocks.size() > 0 && $urandom_range(3) != 0)
                        a = live_blocks[$urandom_range(live_blocks.size() - 1)];
                    push_cmd(CMD_FREE, $urandom, a);
                end
            endcase
        end
    endfunction

    // Shadow the shadow: collect addresses that allocations really returned.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall && o_status == STAT_OK && o_data_addr != 0) begin
            live_blocks.push_back(o_data_addr);
            if (live_blocks.size() > 128) void'(live_blocks.pop_front());
        end
    end

    initial begin
        heap_base = HEAP_START_RST;
        heap_len = HEAP_SIZE_RST;
        rebuild_heap();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every command and every status.
        push_cmd(CMD_ALLOC, 32'd0, 32'd0);
        push_cmd(CMD_ALLOC, 32'd1, 32'd0);
        push_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(CMD_ALLOC, 32'hFFFF_FFE0, 32'd0);
        push_cmd(CMD_ALLOC, 32'd1048576, 32'd0);
        push_cmd(CMD_FREE, 32'd0, HEAP_SIZE_RST - 32'd16);
        push_cmd(CMD_FREE, 32'd0, HEAP_SIZE_RST - 32'd16);
        push_cmd(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < MAX_CHUNKS + 2; k++) push_cmd(CMD_ALLOC, 32'd16, 32'd0);
        push_cmd(CMD_FREE, 32'd0, HEAP_SIZE_RST - 32'd48);
        push_cmd(CMD_INIT, 32'd0, 32'd0);
        drain();

        // Wrap around the top of the address space and a tiny heap.
        reg_write(3'h0, 32'hFFFF_FF00);
        reg_write(3'h4, 32'd4096);
        push_cmd(CMD_INIT, 32'd0, 32'd0);
        send_idle_pct = 35;
        recv_idle_pct = 78;
        push_random(400);
        drain();

        reg_write(3'h0, 32'h0000_0000);
        reg_write(3'h4, 32'hFFFF_FFFF);
        push_cmd(CMD_INIT, 32'd0, 32'd0);
        send_idle_pct = 78;
        recv_idle_pct = 35;
        push_random(400);
        drain();

        reg_write(3'h4, 32'd0);
        push_cmd(CMD_INIT, 32'd0, 32'd0);
        push_random(20);
        drain();

        reg_write(3'h0, 32'h1234_5670);
        reg_write(3'h4, 32'd65536);
        push_cmd(CMD_INIT, 32'd0, 32'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(750);
        drain();

        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
